// ===== rtl/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants of the IPv4-to-MAC resolution table
// Operation codes, ARP reply opcode, table size default and word formats.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam logic [15:0] ARP_REPLY = 16'd2;

    typedef enum logic [1:0] {
        OP_LEARN  = 2'd0,
        OP_SET    = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        frame_is_arp;
        logic [15:0] arp_opcode;
        logic [31:0] ip_key;
        logic [47:0] mac_value;
    } in_word_t;

    typedef struct packed {
        logic        hit;
        logic [47:0] mac_out;
        logic        stored;
        logic        table_full;
    } out_word_t;

endpackage

// ===== rtl/ip_to_mac_resolution_table.sv =====
// ----------------------------------------------------------------------------
// ip_to_mac_resolution_table: fully associative IPv4-to-MAC cache
// Takes one operation word per cycle (learn, set, lookup, remove) unless the
// output stalls, and returns one result word for each. A word is captured in
// the input register, checked against all slots in parallel and written to
// the output register, so a new word is taken while the last one moves on;
// the per-slot comparators and the lowest-free-slot encoder form the work
// between the two registers. Slot updates take effect at the same edge the
// result is registered, so the following word sees them. All slots are
// empty after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ip_to_mac_resolution_table
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic      in_valid_reg;
    logic      in_valid_next;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_word_t out_word_reg;
    out_word_t result;
    logic      advance;

    // move the held word into the output register when it has room
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    arpc_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_table (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (in_word_reg),
        .apply  (advance),
        .result (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_data;
        end
        if (advance) begin
            out_word_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

endmodule

// ===== rtl/arpc_table.sv =====
// ----------------------------------------------------------------------------
// arpc_table: associative key store with per-slot comparators
// Matches the key against every valid slot, picks the lowest free slot for a
// new key, forms the result word and updates the slots when the word moves on.
// ----------------------------------------------------------------------------
module arpc_table
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_word_t  req,
    input  logic      apply,
    output out_word_t result
);

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic [31:0]              ip_reg  [TABLE_ENTRIES];
    logic [47:0]              mac_reg [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] match;
    logic [TABLE_ENTRIES-1:0] free_vec;
    logic [TABLE_ENTRIES-1:0] free_oh;
    logic [TABLE_ENTRIES-1:0] wr_oh;
    logic                     hit;
    logic                     any_free;
    logic                     do_store;
    logic                     store_ok;
    logic [47:0]              mac_sel;

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            match[i] = valid_reg[i] && (ip_reg[i] == req.ip_key);
        end
    end

    assign hit      = |match;
    assign free_vec = ~valid_reg;
    assign any_free = |free_vec;
    // isolate the lowest set bit
    assign free_oh  = free_vec & (~free_vec + {{(TABLE_ENTRIES-1){1'b0}}, 1'b1});
    // keys are unique, so match is one-hot when hit
    assign wr_oh    = hit ? match : free_oh;

    always_comb begin
        mac_sel = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            mac_sel = mac_sel | (match[i] ? mac_reg[i] : 48'd0);
        end
    end

    always_comb begin
        unique case (req.op)
            OP_LEARN:  do_store = req.frame_is_arp && (req.arp_opcode == ARP_REPLY);
            OP_SET:    do_store = 1'b1;
            OP_LOOKUP: do_store = 1'b0;
            OP_REMOVE: do_store = 1'b0;
            default:   do_store = 1'b0;
        endcase
    end

    assign store_ok = do_store && (hit || any_free);

    always_comb begin
        result.hit        = hit;
        result.mac_out    = (req.op == OP_LOOKUP) ? mac_sel : 48'd0;
        result.stored     = store_ok;
        result.table_full = do_store && !hit && !any_free;
    end

    always_comb begin
        valid_next = valid_reg;
        if (apply) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (store_ok && wr_oh[i]) begin
                    valid_next[i] = 1'b1;
                end else if ((req.op == OP_REMOVE) && match[i]) begin
                    valid_next[i] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (apply && store_ok && wr_oh[i]) begin
                ip_reg[i]  <= req.ip_key;
                mac_reg[i] <= req.mac_value;
            end
        end
    end

endmodule

// ===== verif/arp_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arp_result_checker: result predictor and comparator for the ARP cache
// Watches both channels of the cache, keeps its own copy of the slot table,
// works out the result word of every accepted operation and compares each
// accepted result word, field by field, with the oldest one outstanding.
// ----------------------------------------------------------------------------
module arp_result_checker
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_data,
    output int        fail_count,
    output int        pending
);

    logic        cache_valid [TABLE_ENTRIES];
    logic [31:0] cache_ip    [TABLE_ENTRIES];
    logic [47:0] cache_mac   [TABLE_ENTRIES];

    out_word_t   result_q [$];
    int          mismatches;

    // Apply one operation to the shadow table and return its result word.
    function automatic out_word_t resolve_ip(input in_word_t w);
        out_word_t r;
        int        found;
        int        slot;
        logic      do_store;
        r        = '0;
        found    = -1;
        do_store = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (found < 0 && cache_valid[i] && cache_ip[i] == w.ip_key) begin
                found = i;
            end
        end
        r.hit = (found >= 0);
        case (w.op)
            OP_LEARN: begin
                do_store = w.frame_is_arp && (w.arp_opcode == ARP_REPLY);
            end
            OP_SET: begin
                do_store = 1'b1;
            end
            OP_LOOKUP: begin
                if (found >= 0) begin
                    r.mac_out = cache_mac[found];
                end
            end
            default: begin
                if (found >= 0) begin
                    cache_valid[found] = 1'b0;
                end
            end
        endcase
        if (do_store) begin
            slot = found;
            // new key: take the lowest free slot
            for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
                if (found < 0 && !cache_valid[i]) begin
                    slot = i;
                end
            end
            if (slot >= 0) begin
                cache_valid[slot] = 1'b1;
                cache_ip[slot]    = w.ip_key;
                cache_mac[slot]   = w.mac_value;
                r.stored          = 1'b1;
            end else begin
                r.table_full = 1'b1;
            end
        end
        return r;
    endfunction

    initial begin
        mismatches = 0;
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin : watch
        out_word_t want;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                cache_valid[i] = 1'b0;
            end
            result_q.delete();
            pending <= 0;
        end else begin
            // compare first: a result word never belongs to the word taken this edge
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, m_data);
                    mismatches++;
                end else begin
                    want = result_q.pop_front();
                    if (m_data.hit !== want.hit) begin
                        $display("%0t: hit expected %0d actual %0d",
                                 $time, want.hit, m_data.hit);
                        mismatches++;
                    end
                    if (m_data.mac_out !== want.mac_out) begin
                        $display("%0t: mac_out expected %h actual %h",
                                 $time, want.mac_out, m_data.mac_out);
                        mismatches++;
                    end
                    if (m_data.stored !== want.stored) begin
                        $display("%0t: stored expected %0d actual %0d",
                                 $time, want.stored, m_data.stored);
                        mismatches++;
                    end
                    if (m_data.table_full !== want.table_full) begin
                        $display("%0t: table_full expected %0d actual %0d",
                                 $time, want.table_full, m_data.table_full);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                result_q.push_back(resolve_ip(s_data));
            end
            pending <= result_q.size();
        end
        fail_count <= mismatches;
    end

endmodule

// ===== verif/ip_to_mac_resolution_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ip_to_mac_resolution_table_tb: stimulus and verdict for the ARP cache
// Drives directed learn/set/lookup/remove words covering reply filtering,
// overwrite, removal and the full table, then random words over a small key
// pool so the table churns and saturates, with random gaps and stalls on both
// channels. Checking is done by the result checker instantiated alongside.
// ----------------------------------------------------------------------------
module ip_to_mac_resolution_table_tb
    import arpc_pkg::*;
();

    localparam int RANDOM_ITEMS = 850;
    localparam int POOL_SIZE    = 20;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int PAUSE_AT     = 650;
    localparam int CYCLE_LIMIT  = 200000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    int          fail_count;
    int          pending;
    int          items_sent;
    int          cycles;
    logic        gaps_on;
    logic [31:0] key_pool [POOL_SIZE];

    ip_to_mac_resolution_table dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    arp_result_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL ip_to_mac_resolution_table");
            $finish;
        end
    end

    // Offer one word and hold it until taken.
    task automatic send_op(input op_t op, input logic arp, input logic [15:0] opcode,
                           input logic [31:0] ip, input logic [47:0] mac);
        in_word_t w;
        w.op           = op;
        w.frame_is_arp = arp;
        w.arp_opcode   = opcode;
        w.ip_key       = ip;
        w.mac_value    = mac;
        if (gaps_on && $urandom_range(99) < 32) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 32);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Receiver: random stalls, a no-stall window and one long hold-off.
    initial begin : receiver
        int   hold;
        logic held;
        held    = 1'b0;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (!held && items_sent >= HOLD_AT) begin
                held    = 1'b1;
                m_ready <= 1'b0;
                for (hold = 0; hold < HOLD_CYCLES; hold++) begin
                    @(posedge aclk);
                end
            end else if (items_sent >= 200 && items_sent < 350) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 32);
            end
        end
    end

    initial begin : stimulus
        int          n;
        int          r;
        int          remove_weight;
        op_t         op;
        logic        arp;
        logic [15:0] opcode;
        logic [31:0] key;
        logic [31:0] hi;
        logic [31:0] lo;

        cycles     = 0;
        items_sent = 0;
        gaps_on    = 1'b1;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (n = 2; n < POOL_SIZE; n++) begin
            key_pool[n] = $urandom;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reply filtering, extremes, overwrite, removal, full table
        send_op(OP_LOOKUP, 1'b0, 16'h0000, 32'h0000_0000, 48'h0);
        send_op(OP_LEARN, 1'b0, ARP_REPLY, 32'hC0A8_0001, 48'h0A0B_0C0D_0E0F);
        send_op(OP_LEARN, 1'b1, 16'h0001, 32'hC0A8_0001, 48'h0A0B_0C0D_0E0F);
        send_op(OP_LEARN, 1'b1, 16'hFFFF, 32'hC0A8_0001, 48'h0A0B_0C0D_0E0F);
        send_op(OP_LEARN, 1'b1, ARP_REPLY, 32'h0000_0000, 48'h0);
        send_op(OP_LEARN, 1'b1, ARP_REPLY, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_op(OP_LOOKUP, 1'b0, 16'h0000, 32'hFFFF_FFFF, 48'h0);
        send_op(OP_SET, 1'b0, 16'h0000, 32'h0000_0000, 48'h0123_4567_89AB);
        send_op(OP_LEARN, 1'b0, 16'h0000, 32'h0000_0000, 48'hFFFF_0000_FFFF);
        send_op(OP_LOOKUP, 1'b1, 16'hFFFF, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        send_op(OP_REMOVE, 1'b0, 16'h0000, 32'hFFFF_FFFF, 48'h0);
        send_op(OP_REMOVE, 1'b0, 16'h0000, 32'hFFFF_FFFF, 48'h0);
        for (n = 0; n < 15; n++) begin
            send_op(OP_SET, 1'b0, 16'h0000, 32'h0A00_0001 + n, {16'hBEEF, 32'h0 + n});
        end
        send_op(OP_SET, 1'b0, 16'h0000, 32'h0B00_0001, 48'h1111_2222_3333);
        send_op(OP_LEARN, 1'b1, ARP_REPLY, 32'h0B00_0002, 48'h4444_5555_6666);
        send_op(OP_SET, 1'b0, 16'h0000, 32'h0000_0000, 48'h7777_8888_9999);

        // random: stores, lookups and removes over a small key pool, learns mostly well-formed
        remove_weight = 15;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                remove_weight = $urandom_range(35, 5);
            end
            gaps_on = !(n >= 200 && n < 350);
            if (n == PAUSE_AT) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending != 0);
            end
            hi     = $urandom;
            lo     = $urandom;
            arp    = 1'($urandom_range(1));
            opcode = 16'($urandom_range(16'hFFFF));
            key    = ($urandom_range(99) < 5) ? $urandom : key_pool[$urandom_range(POOL_SIZE - 1)];
            r      = $urandom_range(99);
            if (r < remove_weight) begin
                op = OP_REMOVE;
            end else if (r < remove_weight + 25) begin
                op = OP_LOOKUP;
            end else if (r < remove_weight + 25 + (75 - remove_weight) / 2) begin
                op = OP_LEARN;
                if ($urandom_range(99) < 80) begin
                    arp    = 1'b1;
                    opcode = ARP_REPLY;
                end else if ($urandom_range(1)) begin
                    opcode = 16'($urandom_range(3));
                end
            end else begin
                op = OP_SET;
            end
            send_op(op, arp, opcode, key, {hi[15:0], lo});
        end

        // drain
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS ip_to_mac_resolution_table");
        end else begin
            $display("FAIL ip_to_mac_resolution_table");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/arpc_pkg.sv
rtl/arpc_table.sv
rtl/ip_to_mac_resolution_table.sv
verif/arp_result_checker.sv
verif/ip_to_mac_resolution_table_tb.sv
